[rtl/swm_pkg.sv]
// ----------------------------------------------------------------------------
// swm_pkg
// Shared types and defaults for the sliding window median filter.
// ----------------------------------------------------------------------------
package swm_pkg;

	// Default storage and sample sizes
	localparam int MAX_WINDOW_DEF   = 16;
	localparam int SAMPLE_WIDTH_DEF = 32;

	// Window size register: width and reset value
	localparam int CFG_WIDTH    = 5;
	localparam int WINDOW_RESET = 3;

	// Status a cell hands to its neighbors
	typedef struct packed {
		logic valid;  // cell holds a live sample (restart masks it)
		logic le;     // cell sample <= incoming sample
		logic dincl;  // oldest sample sits in this cell or one to its left
	} swm_flags_t;

endpackage

[rtl/swm_cell.sv]
// ----------------------------------------------------------------------------
// swm_cell
// One slot of the sorted window. Holds a sample and its age, and on each
// transaction takes its new content from itself, a neighbor or the input,
// so the row stays sorted with the oldest sample dropped.
// ----------------------------------------------------------------------------
module swm_cell #(
	parameter int SAMPLE_WIDTH = 32,
	parameter int AGE_WIDTH    = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           step,
	input  logic                           flush,
	input  logic                           restart,
	input  logic                           full,
	input  logic [AGE_WIDTH-1:0]           oldest_age,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	input  swm_pkg::swm_flags_t            left_flg,
	input  logic signed [SAMPLE_WIDTH-1:0] left_val,
	input  logic [AGE_WIDTH-1:0]           left_age,
	input  swm_pkg::swm_flags_t            right_flg,
	input  logic signed [SAMPLE_WIDTH-1:0] right_val,
	input  logic [AGE_WIDTH-1:0]           right_age,
	output swm_pkg::swm_flags_t            flg,
	output logic signed [SAMPLE_WIDTH-1:0] val,
	output logic [AGE_WIDTH-1:0]           age
);
	import swm_pkg::*;

	logic                           valid_q;
	logic signed [SAMPLE_WIDTH-1:0] val_q;
	logic [AGE_WIDTH-1:0]           age_q;

	logic                           vld;
	logic                           del;
	swm_flags_t                     rs_flg;
	logic signed [SAMPLE_WIDTH-1:0] rs_val;
	logic [AGE_WIDTH-1:0]           rs_age;
	swm_flags_t                     rl_flg;
	logic signed [SAMPLE_WIDTH-1:0] rl_val;
	logic [AGE_WIDTH-1:0]           rl_age;
	logic                           nxt_valid;
	logic signed [SAMPLE_WIDTH-1:0] nxt_val;
	logic [AGE_WIDTH-1:0]           nxt_age;

	// Local status: live, ordering against the input, oldest sample marker
	always_comb begin
		vld = valid_q && !restart;
		del = vld && full && (age_q == oldest_age);
		flg.valid = vld;
		flg.le    = vld && (val_q <= sample);
		flg.dincl = left_flg.dincl || del;
	end

	assign val = val_q;
	assign age = age_q;

	// Close the gap left by the dropped sample
	always_comb begin
		if (flg.dincl) begin
			rs_flg = right_flg;
			rs_val = right_val;
			rs_age = right_age;
		end else begin
			rs_flg = flg;
			rs_val = val_q;
			rs_age = age_q;
		end
		if (left_flg.dincl) begin
			rl_flg = flg;
			rl_val = val_q;
			rl_age = age_q;
		end else begin
			rl_flg = left_flg;
			rl_val = left_val;
			rl_age = left_age;
		end
	end

	// Open a slot for the new sample: keep, insert here, or shift right
	always_comb begin
		if (rs_flg.le) begin
			nxt_valid = 1'b1;
			nxt_val   = rs_val;
			nxt_age   = rs_age + 1'b1;
		end else if (rl_flg.le) begin
			nxt_valid = 1'b1;
			nxt_val   = sample;
			nxt_age   = '0;
		end else begin
			nxt_valid = rl_flg.valid;
			nxt_val   = rl_val;
			nxt_age   = rl_age + 1'b1;
		end
	end

	// Hold the live flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (flush) begin
			valid_q <= 1'b0;
		end else if (step) begin
			valid_q <= nxt_valid;
		end
	end

	// Advance the sample and its age
	always_ff @(posedge clk) begin
		if (step) begin
			val_q <= nxt_val;
			age_q <= nxt_age;
		end
	end

endmodule

[rtl/swm_median.sv]
// ----------------------------------------------------------------------------
// swm_median
// Picks the two middle cells of the sorted row and adds them, giving twice
// the median (the sum of both middles for an even window).
// ----------------------------------------------------------------------------
module swm_median #(
	parameter int SAMPLE_WIDTH = 32,
	parameter int NUM_CELLS    = 16,
	parameter int CNT_WIDTH    = 5
) (
	input  logic signed [SAMPLE_WIDTH-1:0] cell_val [NUM_CELLS],
	input  logic [CNT_WIDTH-1:0]           window,
	output logic signed [SAMPLE_WIDTH:0]   median_x2
);
	import swm_pkg::*;

	logic [CNT_WIDTH-1:0]    lo_idx;
	logic [CNT_WIDTH-1:0]    hi_idx;
	logic [SAMPLE_WIDTH-1:0] lo_val;
	logic [SAMPLE_WIDTH-1:0] hi_val;

	// Middle positions of the window
	assign lo_idx = (window - 1'b1) >> 1;
	assign hi_idx = window >> 1;

	// Gate each cell onto the lower and upper middle buses
	always_comb begin
		lo_val = '0;
		hi_val = '0;
		for (int i = 0; i < NUM_CELLS; i++) begin
			if (lo_idx == CNT_WIDTH'(i)) begin
				lo_val = lo_val | cell_val[i];
			end
			if (hi_idx == CNT_WIDTH'(i)) begin
				hi_val = hi_val | cell_val[i];
			end
		end
	end

	// Sign extend and add
	assign median_x2 = $signed({lo_val[SAMPLE_WIDTH-1], lo_val})
		+ $signed({hi_val[SAMPLE_WIDTH-1], hi_val});

endmodule

[rtl/sliding_window_median.sv]
// A completing transaction sets pend_s1, which loads the output register once it is free.
// Throughput: one sample per cycle while in_ready is high; each transaction updates the whole cell row at once.
// The output register stalls input only while a finished result cannot be handed on.
// Reset: window size 3, window empty, cell samples unset until written.
// Writing the window size also empties the window.
// ----------------------------------------------------------------------------
// sliding_window_median
// Median filter over the last window_size samples, built as a row of
// sorting cells. Each sample enters its sorted place while the oldest
// sample leaves; the middle cells are summed into twice the median.
// ----------------------------------------------------------------------------
module sliding_window_median #(
	parameter int MAX_WINDOW   = swm_pkg::MAX_WINDOW_DEF,
	parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [swm_pkg::CFG_WIDTH-1:0]      window_size,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0]     sample,
	input  logic                               restart,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [SAMPLE_WIDTH:0]       median_x2
);
	import swm_pkg::*;

	localparam int AGE_WIDTH = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CNT_WIDTH = $clog2(MAX_WINDOW + 1);
	localparam int RST_SIZE  = (WINDOW_RESET > MAX_WINDOW) ? MAX_WINDOW : WINDOW_RESET;

	logic [CNT_WIDTH-1:0]           win_q;
	logic [CNT_WIDTH-1:0]           win_nxt;
	logic [CNT_WIDTH-1:0]           cnt_q;
	logic [CNT_WIDTH-1:0]           cnt_nxt;
	logic [CNT_WIDTH-1:0]           win_m1;
	logic [AGE_WIDTH-1:0]           oldest_age;
	logic                           full;
	logic                           in_xfer;
	logic                           out_free;
	logic                           pend_s1;
	logic signed [SAMPLE_WIDTH:0]   sum;
	logic signed [SAMPLE_WIDTH:0]   median_q;
	logic                           out_valid_q;

	swm_flags_t                     flg [MAX_WINDOW];
	logic signed [SAMPLE_WIDTH-1:0] val [MAX_WINDOW];
	logic [AGE_WIDTH-1:0]           age [MAX_WINDOW];

	// Handshake
	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = !pend_s1 || out_free;
	assign in_xfer   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign median_x2 = median_q;

	// Clamp the written window size into range
	always_comb begin
		if (window_size == '0) begin
			win_nxt = CNT_WIDTH'(1);
		end else if (int'(window_size) > MAX_WINDOW) begin
			win_nxt = CNT_WIDTH'(MAX_WINDOW);
		end else begin
			win_nxt = CNT_WIDTH'(window_size);
		end
	end

	// Fill count after this sample and the age of the sample to drop
	assign full       = (cnt_q == win_q);
	assign win_m1     = win_q - 1'b1;
	assign oldest_age = win_m1[AGE_WIDTH-1:0];

	always_comb begin
		if (restart) begin
			cnt_nxt = CNT_WIDTH'(1);
		end else if (full) begin
			cnt_nxt = cnt_q;
		end else begin
			cnt_nxt = cnt_q + 1'b1;
		end
	end

	// Window size and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= CNT_WIDTH'(RST_SIZE);
			cnt_q <= '0;
		end else if (cfg_wr_en) begin
			win_q <= win_nxt;
			cnt_q <= '0;
		end else if (in_xfer) begin
			cnt_q <= cnt_nxt;
		end
	end

	// Row of sorting cells
	for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
		swm_flags_t                     l_flg;
		logic signed [SAMPLE_WIDTH-1:0] l_val;
		logic [AGE_WIDTH-1:0]           l_age;
		swm_flags_t                     r_flg;
		logic signed [SAMPLE_WIDTH-1:0] r_val;
		logic [AGE_WIDTH-1:0]           r_age;

		// Left edge accepts the new sample; right edge is an empty slot
		if (i == 0) begin : g_left_edge
			assign l_flg = '{valid: 1'b0, le: 1'b1, dincl: 1'b0};
			assign l_val = '0;
			assign l_age = '0;
		end else begin : g_left
			assign l_flg = flg[i-1];
			assign l_val = val[i-1];
			assign l_age = age[i-1];
		end

		if (i == MAX_WINDOW - 1) begin : g_right_edge
			assign r_flg = '{valid: 1'b0, le: 1'b0, dincl: 1'b0};
			assign r_val = '0;
			assign r_age = '0;
		end else begin : g_right
			assign r_flg = flg[i+1];
			assign r_val = val[i+1];
			assign r_age = age[i+1];
		end

		swm_cell #(
			.SAMPLE_WIDTH (SAMPLE_WIDTH),
			.AGE_WIDTH    (AGE_WIDTH)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.step       (in_xfer),
			.flush      (cfg_wr_en),
			.restart    (restart),
			.full       (full),
			.oldest_age (oldest_age),
			.sample     (sample),
			.left_flg   (l_flg),
			.left_val   (l_val),
			.left_age   (l_age),
			.right_flg  (r_flg),
			.right_val  (r_val),
			.right_age  (r_age),
			.flg        (flg[i]),
			.val        (val[i]),
			.age        (age[i])
		);
	end

	// Middle pick and sum
	swm_median #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.NUM_CELLS    (MAX_WINDOW),
		.CNT_WIDTH    (CNT_WIDTH)
	) u_median (
		.cell_val  (val),
		.window    (win_q),
		.median_x2 (sum)
	);

	// Track a completed window waiting for the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 1'b0;
		end else if (in_xfer) begin
			pend_s1 <= (cnt_nxt == win_q);
		end else if (out_free) begin
			pend_s1 <= 1'b0;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pend_s1 && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Capture the result
	always_ff @(posedge clk) begin
		if (pend_s1 && out_free) begin
			median_q <= sum;
		end
	end

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sliding window median filter. A behavioral
// window model predicts twice the median for each accepted sample of a full
// window; results are matched in order against it while both handshakes
// idle at random, the window size sweeps its full register range, and
// restarts and long output stalls exercise fill, flush and backpressure.
// ----------------------------------------------------------------------------
module tb;

	import swm_pkg::*;

	localparam int MAX_WIN        = MAX_WINDOW_DEF;
	localparam int SW             = SAMPLE_WIDTH_DEF;
	localparam int CFG_W          = CFG_WIDTH;
	localparam int TOTAL_ITEMS    = 1050;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 300;

	localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};
	localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};

	// DUT ports
	logic                   clk         = 1'b0;
	logic                   arst_n      = 1'b0;
	logic                   cfg_wr_en   = 1'b0;
	logic [CFG_W-1:0]       window_size = CFG_W'(WINDOW_RESET);
	logic                   in_valid    = 1'b0;
	logic                   in_ready;
	logic signed [SW-1:0]   sample      = '0;
	logic                   restart     = 1'b0;
	logic                   out_valid;
	logic                   out_ready   = 1'b0;
	logic signed [SW:0]     median_x2;

	// Window model state
	logic signed [SW-1:0]   win_store [MAX_WIN];
	logic [CFG_W-1:0]       win_cfg    = CFG_W'(WINDOW_RESET);
	int unsigned            fill_count = 0;
	int unsigned            next_slot  = 0;
	logic signed [SW:0]     medians_due [$];

	// Traffic shaping and bookkeeping
	bit tx_gaps_on  = 1'b0;
	bit rx_stall_on = 1'b0;
	int rx_hold     = 0;
	int items_sent  = 0;
	int error_count = 0;
	int idle_cycles = 0;

	sliding_window_median DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.window_size (window_size),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.sample      (sample),
		.restart     (restart),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.median_x2   (median_x2)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Log one mismatch and count it
	task automatic flag_error(input string msg);
		if (error_count < 50) begin
			$display("ERROR @%0t: %s", $time, msg);
		end
		error_count++;
	endtask

	// Advance the window model by one sample and queue the median it yields
	task automatic predict_median(input logic signed [SW-1:0] s, input logic rst);
		int unsigned          w;
		int                   j;
		logic signed [SW-1:0] srt [MAX_WIN];
		logic signed [SW-1:0] v;
		logic signed [SW:0]   m2;
		w = (win_cfg == 0) ? 1 : ((win_cfg > MAX_WIN) ? MAX_WIN : win_cfg);
		if (rst) begin
			fill_count = 0;
			next_slot  = 0;
		end
		if (fill_count < w) begin
			win_store[fill_count] = s;
			fill_count++;
		end else begin
			win_store[next_slot] = s;
			next_slot = (next_slot + 1) % w;
		end
		if (fill_count == w) begin
			// insertion sort of the live window
			for (int i = 0; i < w; i++) begin
				v = win_store[i];
				j = i;
				while (j > 0 && srt[j-1] > v) begin
					srt[j] = srt[j-1];
					j--;
				end
				srt[j] = v;
			end
			m2 = {srt[(w-1)/2][SW-1], srt[(w-1)/2]} + {srt[w/2][SW-1], srt[w/2]};
			medians_due = {medians_due, m2};
		end
	endtask

	// Check each output transaction, then predict from each input transaction
	always @(posedge clk) begin : track_medians
		logic signed [SW:0] want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (medians_due.size() == 0) begin
					flag_error($sformatf("unexpected median_x2 %0d", median_x2));
				end else begin
					want = medians_due.pop_front();
					if (median_x2 !== want) begin
						flag_error($sformatf("median_x2 got %0d want %0d", median_x2, want));
					end
				end
			end
			if (in_valid && in_ready) begin
				predict_median(sample, restart);
			end
		end
	end

	// End the run when no transaction moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en) begin
				idle_cycles <= 0;
			end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
				$display("** sliding_window_median: FAILED **");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// Mostly short gaps, some medium, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 19);
		if (r < 15) return $urandom_range(1, 3);
		if (r < 19) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Full-range values, small values for ties, and the extremes
	function automatic logic signed [SW-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom;
			4, 5, 6:    return $urandom_range(0, 16) - 8;
			7:          return S_MIN;
			8:          return S_MAX;
			default:    return ($urandom_range(0, 1) != 0) ? S_MIN + $urandom_range(0, 3)
			                                               : S_MAX - $urandom_range(0, 3);
		endcase
	endfunction

	// Mostly legal sizes, sometimes zero or above the store depth
	function automatic logic [CFG_W-1:0] pick_window();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return CFG_W'($urandom_range(MAX_WIN + 1, (1 << CFG_W) - 1));
			default: return CFG_W'($urandom_range(1, MAX_WIN));
		endcase
	endfunction

	// Drive output ready: random stalls, or a long hold when one is requested
	initial begin : drive_out_ready
		int gap;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rx_hold > 0) begin
				out_ready <= 1'b0;
				repeat (rx_hold - 1) @(negedge clk);
				rx_hold = 0;
			end else if (rx_stall_on && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				gap = pick_gap();
				repeat (gap - 1) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Offer one sample and hold it until accepted; maybe idle afterwards
	task automatic send_sample(input logic signed [SW-1:0] s, input logic rst);
		int gap;
		@(negedge clk);
		in_valid <= 1'b1;
		sample   <= s;
		restart  <= rst;
		do @(posedge clk); while (!in_ready);
		items_sent++;
		if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
			gap = pick_gap();
			@(negedge clk);
			in_valid <= 1'b0;
			sample   <= $urandom;
			restart  <= 1'b1;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// Stop sending and wait until every expected median has come out
	task automatic settle_outputs();
		@(negedge clk);
		in_valid <= 1'b0;
		while (medians_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write the window size; the block is idle, so the window empties here too
	task automatic write_window(input logic [CFG_W-1:0] v);
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		window_size <= v;
		win_cfg    = v;
		fill_count = 0;
		next_slot  = 0;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Extremes through the reset window of three
	task automatic test_extreme_samples();
		tx_gaps_on  = 1'b1;
		rx_stall_on = 1'b1;
		send_sample(S_MIN, 1'b0);
		send_sample(S_MAX, 1'b0);
		send_sample('0, 1'b0);
		send_sample('1, 1'b0);
		send_sample(S_MAX, 1'b0);
		send_sample(S_MAX, 1'b0);
		send_sample(S_MIN, 1'b0);
		send_sample(S_MIN, 1'b0);
		send_sample(S_MIN, 1'b0);
	endtask

	// Restart before the window fills, and restart with a window of one
	task automatic test_restart();
		send_sample(5, 1'b1);
		send_sample(6, 1'b0);
		send_sample(7, 1'b1);
		send_sample(8, 1'b0);
		send_sample(9, 1'b0);
		settle_outputs();
		write_window(1);
		send_sample(-3, 1'b1);
		send_sample(S_MAX, 1'b1);
	endtask

	// Even window sums of the extremes, and size zero acting as one
	task automatic test_window_edges();
		settle_outputs();
		write_window(2);
		send_sample(S_MAX, 1'b0);
		send_sample(S_MAX, 1'b0);
		send_sample(S_MIN, 1'b0);
		send_sample(S_MIN, 1'b0);
		settle_outputs();
		write_window('0);
		send_sample(12345, 1'b0);
	endtask

	// Hold the output off for a long stretch while samples keep coming
	task automatic test_backpressure_fill();
		settle_outputs();
		write_window(4);
		tx_gaps_on  = 1'b0;
		rx_stall_on = 1'b0;
		rx_hold     = HOLD_CYCLES;
		repeat (40) send_sample(pick_sample(), 1'b0);
		settle_outputs();
	endtask

	// Random sequences over a sweep of window sizes
	task automatic test_random_stream();
		logic [CFG_W-1:0] forced [5];
		int               phase;
		int               burst;
		forced = '{CFG_W'(MAX_WIN), '1, CFG_W'(MAX_WIN + 1), '0, CFG_W'(1)};
		phase  = 0;
		while (items_sent < TOTAL_ITEMS) begin
			settle_outputs();
			write_window((phase < 5) ? forced[phase] : pick_window());
			tx_gaps_on  = ($urandom_range(0, 3) != 0);
			rx_stall_on = ($urandom_range(0, 3) != 0);
			burst = $urandom_range(20, 70);
			repeat (burst) begin
				// pause the sender now and then until the output catches up
				if ($urandom_range(0, 31) == 0) begin
					settle_outputs();
				end
				send_sample(pick_sample(), $urandom_range(0, 24) == 0);
			end
			phase++;
		end
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		test_extreme_samples();
		test_restart();
		test_window_edges();
		test_backpressure_fill();
		test_random_stream();
		settle_outputs();
		repeat (10) @(posedge clk);
		if (error_count == 0 && medians_due.size() == 0) begin
			$display("** sliding_window_median: PASSED **");
		end else begin
			$display("** sliding_window_median: FAILED **");
		end
		$finish;
	end

endmodule
